/* design/dq_pkg.sv */
// dq_pkg: shared types and constants for the double-ended queue.
// Holds opcode and status codes, the per-cell control struct and sizes.
// No dependencies.
package dq_pkg;

    localparam int DATA_W       = 32;
    localparam int OPCODE_W     = 3;
    localparam int INDEX_W      = 4;
    localparam int STATUS_W     = 2;
    localparam int OCCUPANCY_W  = 5;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_READ       = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Per-cell update command; at most one bit is set in a cycle.
    typedef struct packed {
        logic take_prev;  // shift toward the back (push front)
        logic take_next;  // shift toward the front (pop front)
        logic load;       // write the pushed word (push back)
    } cell_ctrl_t;

endpackage

/* design/dq_cell.sv */
// dq_cell: one storage slot of the deque chain.
// Takes its word from the front neighbor, the back neighbor or the push data.
// Depends on dq_pkg.
module dq_cell (
    input  logic                               aclk,
    input  dq_pkg::cell_ctrl_t                 ctrl,
    input  logic signed [dq_pkg::DATA_W-1:0]   prev_data,
    input  logic signed [dq_pkg::DATA_W-1:0]   next_data,
    input  logic signed [dq_pkg::DATA_W-1:0]   load_data,
    output logic signed [dq_pkg::DATA_W-1:0]   word
);
    import dq_pkg::*;

    logic signed [DATA_W-1:0] word_reg;
    logic signed [DATA_W-1:0] word_next;

    always_comb begin
        word_next = word_reg;
        if (ctrl.take_prev) begin
            word_next = prev_data;
        end else if (ctrl.take_next) begin
            word_next = next_data;
        end else if (ctrl.load) begin
            word_next = load_data;
        end
    end

    // Payload only, no reset.
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* design/double_ended_queue_top.sv */
// double_ended_queue_top: fixed-capacity deque of signed 32-bit words.
// A transaction's result is presented in the cycle after acceptance.
// Throughput: one transaction per cycle while m_ready takes results.
// Reset (aresetn low, synchronous): element count and output valid clear;
// cell contents are left as they are and only read below the count.
// Depends on dq_pkg and dq_cell.
module double_ended_queue_top #(
    parameter int CAPACITY = dq_pkg::CAPACITY_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // operation channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [dq_pkg::OPCODE_W-1:0]          s_opcode,
    input  logic signed [dq_pkg::DATA_W-1:0]     s_value,
    input  logic [dq_pkg::INDEX_W-1:0]           s_index,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [dq_pkg::STATUS_W-1:0]          m_status,
    output logic signed [dq_pkg::DATA_W-1:0]     m_data,
    output logic [dq_pkg::OCCUPANCY_W-1:0]       m_occupancy
);
    import dq_pkg::*;

    // Widths: cell address, count (holds CAPACITY itself), and the width
    // used to compare an index with the count.
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic                      m_valid_reg;
    status_t                   m_status_reg;
    logic signed [DATA_W-1:0]  m_data_reg;
    logic [OCCUPANCY_W-1:0]    m_occupancy_reg;

    logic s_fire;
    logic full;
    logic empty;

    // Output register frees up in the same cycle it is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    assign full  = (count_reg == CW'(CAPACITY));
    assign empty = (count_reg == '0);

    // ---------------------------------------------------------------
    // Cell chain: cell 0 is the front of the queue.
    // ---------------------------------------------------------------
    logic signed [DATA_W-1:0] cell_word [CAPACITY];
    cell_ctrl_t               cell_ctrl [CAPACITY];

    // Decoded shift/load commands, common to all cells except for the
    // push-back target which is the cell at the current count.
    logic do_shift_back;
    logic do_shift_fwd;
    logic do_push_back;

    // Read port: the back word for pop back, otherwise the indexed word.
    logic [IW-1:0]            index_ext;
    logic [IW-1:0]            count_ext;
    logic [AW-1:0]            rd_addr;
    logic signed [DATA_W-1:0] rd_word;
    logic                     index_ok;

    assign index_ext = IW'(s_index);
    assign count_ext = IW'(count_reg);
    assign index_ok  = (index_ext < count_ext);

    assign rd_addr = (s_opcode == OP_POP_BACK) ? AW'(count_reg - 1'b1)
                                               : AW'(index_ext);
    assign rd_word = cell_word[rd_addr];

    status_t                  status_sel;
    logic signed [DATA_W-1:0] data_sel;

    always_comb begin
        status_sel    = ST_OK;
        data_sel      = '0;
        count_next    = count_reg;
        do_shift_back = 1'b0;
        do_shift_fwd  = 1'b0;
        do_push_back  = 1'b0;
        unique case (s_opcode)
            OP_PUSH_FRONT: begin
                if (full) begin
                    status_sel = ST_FULL;
                end else begin
                    do_shift_back = 1'b1;
                    count_next    = count_reg + 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    status_sel = ST_FULL;
                end else begin
                    do_push_back = 1'b1;
                    count_next   = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    status_sel = ST_EMPTY;
                end else begin
                    data_sel     = cell_word[0];
                    do_shift_fwd = 1'b1;
                    count_next   = count_reg - 1'b1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    status_sel = ST_EMPTY;
                end else begin
                    data_sel   = rd_word;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_READ: begin
                if (!index_ok) begin
                    status_sel = ST_RANGE;
                end else begin
                    data_sel = rd_word;
                end
            end
            default: begin
                // unused opcodes: no change, ok status, zero data
            end
        endcase
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] prev_w;
        logic signed [DATA_W-1:0] next_w;

        if (i == 0) begin : g_front
            assign prev_w = s_value;        // push front enters here
        end else begin : g_mid_prev
            assign prev_w = cell_word[i-1];
        end

        if (i == CAPACITY - 1) begin : g_back
            assign next_w = cell_word[i];   // last slot: don't care on pop
        end else begin : g_mid_next
            assign next_w = cell_word[i+1];
        end

        always_comb begin
            cell_ctrl[i].take_prev = s_fire && do_shift_back;
            cell_ctrl[i].take_next = s_fire && do_shift_fwd;
            cell_ctrl[i].load      = s_fire && do_push_back
                                     && (count_reg == CW'(i));
        end

        dq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .prev_data (prev_w),
            .next_data (next_w),
            .load_data (s_value),
            .word      (cell_word[i])
        );
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted transaction.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_status_reg    <= status_sel;
            m_data_reg      <= data_sel;
            m_occupancy_reg <= OCCUPANCY_W'(count_next);
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = m_status_reg;
    assign m_data      = m_data_reg;
    assign m_occupancy = m_occupancy_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_push_back_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_opcode == OP_PUSH_BACK && !full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push back did not grow the count");

    a_err_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_OK |-> m_data_reg == '0)
        else $error("nonzero data with error status");

    a_pop_front_data: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_opcode == OP_POP_FRONT && !empty
        |=> m_data_reg == $past(cell_word[0]))
        else $error("pop front returned wrong word");

    a_push_front_head: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_opcode == OP_PUSH_FRONT && !full
        |=> cell_word[0] == $past(s_value))
        else $error("push front word not at head");

endmodule
